@@ rtl/dbramp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dB ramp fade in/out unit.
// No dependencies.
package dbramp_pkg;

   localparam int unsigned FracBits = 28;

   localparam logic [31:0] GAIN_START = 32'd26843546;  // 0.1 in Q4.28
   localparam logic [31:0] GAIN_ONE   = 32'd268435456; // 1.0 in Q4.28

   localparam logic [31:0] CLIP_LENGTH_RESET = 32'd48000;
   localparam logic [31:0] FACTOR_RESET      = 32'd268435456;

   // csr register indexes
   localparam logic [1:0] CSR_CLIP_LENGTH = 2'd0;
   localparam logic [1:0] CSR_RISE_FACTOR = 2'd1;
   localparam logic [1:0] CSR_FALL_FACTOR = 2'd2;

   typedef struct packed {
      logic signed [15:0] sample_left;
      logic signed [15:0] sample_right;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] faded_left;
      logic signed [15:0] faded_right;
      logic               clip_end;
   } rsp_data_type;

endpackage

@@ rtl/db_ramp_fade_in_out_unit.sv @@
`timescale 1ns / 1ps
// Top level of the dB ramp fade in/out unit: gain recurrence and sample scaling.
// Depends on dbramp_pkg.
//
// Applies a logarithmic fade envelope to a stream of stereo sample pairs. The
// gain starts at 0.1, is multiplied by rise_factor after every sample of the
// first half of the clip, is forced to 1.0 at the midpoint and is multiplied
// by fall_factor afterwards; after the last sample (flagged by clip_end) the
// position and gain return to their start values. Throughput is one sample
// pair per clock while rsp_ready is high. A beat is captured in the input
// register when accepted, moves to the output register once that is free
// and is taken while rsp_ready is high. The per-clock rate is set by the
// gain recurrence: one 32x32 multiply with rounding and saturation, closed
// combinationally on the gain register. Configuration is to be written by
// the user only while no beat is in flight; the block does not enforce it.
module db_ramp_fade_in_out_unit
   import dbramp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,

   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   function automatic logic [15:0] scale_sample(input logic [15:0] s, input logic [31:0] g);
      logic [16:0] mag;
      logic [48:0] prod;
      logic [20:0] q;
      logic [15:0] r;
      mag  = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
      prod = 49'(mag) * 49'(g);
      q    = prod[48:FracBits];
      if (s[15]) begin
         if (q > 21'd32768) q = 21'd32768;
         r = 16'(17'h10000 - 17'(q[15:0]));
      end else begin
         r = (q > 21'd32767) ? 16'h7fff : q[15:0];
      end
      return r;
   endfunction

   // configuration
   logic [31:0] clip_length_ff;
   logic [31:0] rise_factor_ff;
   logic [31:0] fall_factor_ff;

   // envelope state
   logic [31:0] position_ff, position_in;
   logic [31:0] gain_ff, gain_in;

   // input stage
   logic         s1_valid_ff, s1_valid_in;
   req_data_type s1_data_ff;
   logic [31:0]  s1_gain_ff;
   logic         s1_last_ff;

   // output stage
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;

   logic        req_fire;
   logic        s1_move;
   logic        out_free;
   logic [31:0] half;
   logic        last;
   logic        at_half;
   logic        rising;
   logic [31:0] eff_gain;
   logic [31:0] factor;
   logic [63:0] gain_prod;
   logic [35:0] gain_q;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign half     = clip_length_ff >> 1;
   assign last     = ({1'b0, position_ff} + 33'd1) >= {1'b0, clip_length_ff};
   assign at_half  = position_ff == half;
   assign rising   = position_ff < half;
   assign eff_gain = at_half ? GAIN_ONE : gain_ff;
   assign factor   = rising ? rise_factor_ff : fall_factor_ff;

   // round to nearest, ties up; cannot overflow 64 bits
   assign gain_prod = 64'(eff_gain) * 64'(factor) + (64'd1 << (FracBits - 1));
   assign gain_q    = gain_prod[63:FracBits];

   always_comb begin
      position_in  = position_ff;
      gain_in      = gain_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         if (last) begin
            position_in = '0;
            gain_in     = GAIN_START;
         end else begin
            position_in = position_ff + 32'd1;
            gain_in     = (|gain_q[35:32]) ? 32'hffff_ffff : gain_q[31:0];
         end
      end
      if (req_fire) s1_valid_in = 1'b1;
      else if (s1_move) s1_valid_in = 1'b0;
      if (s1_move) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_length_ff <= CLIP_LENGTH_RESET;
         rise_factor_ff <= FACTOR_RESET;
         fall_factor_ff <= FACTOR_RESET;
         position_ff    <= '0;
         gain_ff        <= GAIN_START;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_CLIP_LENGTH: clip_length_ff <= csr_wdata;
               CSR_RISE_FACTOR: rise_factor_ff <= csr_wdata;
               CSR_FALL_FACTOR: fall_factor_ff <= csr_wdata;
               default: ;
            endcase
         end
         position_ff  <= position_in;
         gain_ff      <= gain_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
         s1_gain_ff <= eff_gain;
         s1_last_ff <= last;
      end
      if (s1_move) begin
         rsp_data_ff.faded_left  <= scale_sample(s1_data_ff.sample_left, s1_gain_ff);
         rsp_data_ff.faded_right <= scale_sample(s1_data_ff.sample_right, s1_gain_ff);
         rsp_data_ff.clip_end    <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for db_ramp_fade_in_out_unit: directed envelope cases,
// then random clips under three idle patterns. Depends on dbramp_pkg.
module tb_top;
   import dbramp_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = CSR_CLIP_LENGTH;
   logic [31:0]  csr_wdata = '0;

   // envelope predictor state, mirrors the block's registers
   logic [31:0]  fade_len = CLIP_LENGTH_RESET;
   logic [31:0]  rise_q = FACTOR_RESET;
   logic [31:0]  fall_q = FACTOR_RESET;
   logic [31:0]  fade_pos = '0;
   logic [31:0]  fade_gain = GAIN_START;

   rsp_data_type faded_queue[$];
   int unsigned  errors = 0;
   int unsigned  send_idle_pct = 13;
   int unsigned  recv_stall_pct = 54;

   db_ramp_fade_in_out_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // sample * gain in Q4.28, truncated toward zero, saturated to 16 bits
   function automatic logic signed [15:0] scale_by_gain(logic signed [15:0] s,
                                                       logic [31:0] g);
      longint          v;
      longint unsigned mag;
      longint unsigned q;
      v = s;
      mag = (v < 0) ? -v : v;
      q = (mag * g) >> FracBits;
      if (v < 0) begin
         if (q > 32768) q = 32768;
         return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return 16'(q);
   endfunction

   // gain * factor, round half up, saturate to 32 bits
   function automatic logic [31:0] step_gain(logic [31:0] g, logic [31:0] f);
      longint unsigned p;
      p = (64'(g) * 64'(f) + (64'd1 << (FracBits - 1))) >> FracBits;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   function automatic rsp_data_type predict_fade(req_data_type d);
      logic [31:0]  half;
      logic         last;
      rsp_data_type r;
      half = fade_len >> 1;
      last = ({1'b0, fade_pos} + 33'd1) >= {1'b0, fade_len};
      if (fade_pos == half) fade_gain = GAIN_ONE;
      r.faded_left  = scale_by_gain(d.sample_left, fade_gain);
      r.faded_right = scale_by_gain(d.sample_right, fade_gain);
      r.clip_end    = last;
      if (last) begin
         fade_pos  = '0;
         fade_gain = GAIN_START;
      end else begin
         fade_gain = step_gain(fade_gain, (fade_pos < half) ? rise_q : fall_q);
         fade_pos  = fade_pos + 32'd1;
      end
      return r;
   endfunction

   function automatic req_data_type mk_pair(logic signed [15:0] l, logic signed [15:0] r);
      req_data_type p;
      p.sample_left  = l;
      p.sample_right = r;
      return p;
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(11))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] pick_factor();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return GAIN_START;
         2: return 32'd2684354560;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // call right after a rising edge; returns in the step of the accepting edge
   task automatic send_pair(input req_data_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      faded_queue.push_back(predict_fade(d));
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (faded_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_fade_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_CLIP_LENGTH: fade_len = value;
         CSR_RISE_FACTOR: rise_q = value;
         CSR_FALL_FACTOR: fall_q = value;
         default: ;
      endcase
   endtask

   task automatic program_fade(input logic [31:0] len, input logic [31:0] rise,
                               input logic [31:0] fall);
      settle_pipeline();
      write_fade_reg(CSR_CLIP_LENGTH, len);
      write_fade_reg(CSR_RISE_FACTOR, rise);
      write_fade_reg(CSR_FALL_FACTOR, fall);
      csr_wr_en <= 1'b0;
   endtask

   task automatic note_mismatch(input string field, input int want, input int got);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
   endtask

   // result side: random stalls, compare each beat against the oldest prediction
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (faded_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none got %h", $time, rsp_data);
         end else begin
            want = faded_queue.pop_front();
            if (rsp_data.faded_left !== want.faded_left)
               note_mismatch("faded_left", want.faded_left, rsp_data.faded_left);
            if (rsp_data.faded_right !== want.faded_right)
               note_mismatch("faded_right", want.faded_right, rsp_data.faded_right);
            if (rsp_data.clip_end !== want.clip_end)
               note_mismatch("clip_end", want.clip_end, rsp_data.clip_end);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // reset config: gain stays at 0.1 with unity factors
   task automatic test_reset_gain();
      send_pair(mk_pair(16'sh7FFF, 16'sh8000));
      send_pair(mk_pair(16'sh8000, 16'sh7FFF));
      send_pair(mk_pair(16'sh0000, 16'shFFFF));
      send_pair(mk_pair(16'sh0001, 16'sh5555));
      send_pair(mk_pair(16'shAAAA, 16'sh0009));
   endtask

   // lengths 1 and 0 pass unchanged at position zero; length 3 hits midpoint early
   task automatic test_short_clips();
      program_fade(32'd1, FACTOR_RESET, FACTOR_RESET);
      send_pair(mk_pair(16'sh7FFF, 16'sh8000));
      send_pair(mk_pair(16'sh1234, 16'shFFFF));
      program_fade(32'd0, FACTOR_RESET, FACTOR_RESET);
      send_pair(mk_pair(16'sh8000, 16'sh7FFF));
      send_pair(mk_pair(16'sh0000, 16'sh0001));
      program_fade(32'd3, 32'd2684354560, GAIN_START);
      send_pair(mk_pair(16'sh7FFF, 16'sh8000));
      send_pair(mk_pair(16'sh4000, 16'shC000));
      send_pair(mk_pair(16'sh8000, 16'sh7FFF));
   endtask

   // gain saturates on the way up, collapses to zero on the way down
   task automatic test_gain_saturation();
      program_fade(32'd6, 32'hFFFF_FFFF, 32'd0);
      send_pair(mk_pair(16'sh7FFF, 16'sh8000));
      send_pair(mk_pair(16'sh7FFF, 16'sh8000));
      send_pair(mk_pair(16'sh0100, 16'shFF00));
      send_pair(mk_pair(16'sh8000, 16'sh7FFF));
      send_pair(mk_pair(16'sh7FFF, 16'sh8000));
      send_pair(mk_pair(16'sh7FFF, 16'shFFFF));
   endtask

   // a length written below the current position ends the clip on the next sample
   task automatic test_shorten_mid_clip();
      program_fade(32'd100, 32'd2684354560, GAIN_START);
      repeat (4) send_pair(mk_pair(16'sh0FFF, 16'shF001));
      program_fade(32'd2, 32'd2684354560, GAIN_START);
      send_pair(mk_pair(16'sh0FFF, 16'shF001));
      send_pair(mk_pair(16'sh7FFF, 16'sh8000));
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned n_pairs);
      int unsigned sent;
      int unsigned burst;
      int unsigned half_len;
      logic [31:0] len;
      logic [31:0] rise;
      logic [31:0] fall;
      real         up;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_pairs) begin
         case ($urandom_range(19))
            0: len = 32'($urandom_range(1));
            1: len = 32'hFFFF_FFFF;
            2: len = CLIP_LENGTH_RESET;
            3: len = $urandom();
            default: len = 32'($urandom_range(64, 2));
         endcase
         // realistic dB-step factors for the clip, now and then wild ones
         half_len = (len >= 2 && len <= 128) ? len >> 1 : $urandom_range(32, 1);
         up   = 10.0 ** (1.0 / half_len);
         rise = 32'(longint'(up * 268435456.0));
         fall = 32'(longint'(268435456.0 / up));
         case ($urandom_range(9))
            0: begin
               rise = $urandom();
               fall = $urandom();
            end
            1: begin
               rise = pick_factor();
               fall = pick_factor();
            end
            default: ;
         endcase
         program_fade(len, rise, fall);
         burst = (len >= 2 && len <= 64) ? $urandom_range(3 * len, 1) : $urandom_range(40, 4);
         if (burst > n_pairs - sent) burst = n_pairs - sent;
         repeat (burst) send_pair(mk_pair(pick_sample(), pick_sample()));
         sent += burst;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_gain();
      test_short_clips();
      test_gain_saturation();
      test_shorten_mid_clip();
      test_random_traffic(13, 54, 410);
      test_random_traffic(54, 13, 410);
      test_random_traffic(0, 0, 410);
      settle_pipeline();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/dbramp_pkg.sv
rtl/db_ramp_fade_in_out_unit.sv
tb/tb_top.sv
